### sv/thc_pkg.sv
package thc_pkg;

	localparam int FIELD_W = 16;
	localparam int ANG_W = 32;
	localparam int MAG_W = 44;
	localparam int ROOT_W = 32;
	localparam int SQRT_W = 64;
	localparam int K_W = 17;
	localparam int TAB_LEN = 32;

	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_CORDIC_STEPS = 16;

	localparam logic signed [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 32'sh4000_0000;
	localparam logic signed [ANG_W-1:0] NEG_QUARTER_TURN = -32'sh4000_0000;
	localparam logic [K_W-1:0] INV_GAIN_Q16 = 17'd39797;
	localparam logic [31:0] ROUND_HALF = 32'd32768;

	// arctan(2^-i) in binary angle units, 2^32 per turn
	localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5,
		32'sd3, 32'sd1, 32'sd1, 32'sd0
	};

	typedef struct packed {
		logic signed [FIELD_W-1:0] accel_x;
		logic signed [FIELD_W-1:0] accel_y;
		logic signed [FIELD_W-1:0] accel_z;
		logic signed [FIELD_W-1:0] mag_x;
		logic signed [FIELD_W-1:0] mag_y;
		logic signed [FIELD_W-1:0] mag_z;
	} sample_t;

	typedef struct packed {
		logic [FIELD_W-1:0] heading_angle;
		logic signed [FIELD_W-1:0] roll_angle;
		logic signed [FIELD_W-1:0] pitch_angle;
	} result_t;

	// round a 32-bit binary angle to 16 bits, half up
	function automatic logic [FIELD_W-1:0] ang16(input logic signed [ANG_W-1:0] z);
		logic [ANG_W-1:0] s;
		s = z + ROUND_HALF;
		return s[ANG_W-1:ANG_W-FIELD_W];
	endfunction

endpackage

### sv/thc_sqrt.sv
module thc_sqrt #(
	parameter int SW = 16,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [SW-1:0] ay,
	input logic signed [SW-1:0] az,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	input logic out_stall,
	output logic [thc_pkg::ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] side_out
);
	import thc_pkg::*;

	localparam int PG = 32 - SW;
	localparam int ND = ROOT_W + 1;
	localparam int NS = ND + 1;

	logic [NS-1:0] v_s, v_prev, adv;
	logic [2*SW-1:0] sqy_s0, sqz_s0;
	logic signed [2*SW-1:0] sqy_p, sqz_p;
	logic [SQRT_W-1:0] n_s [ND];
	logic [SQRT_W-1:0] n_n [ND];
	logic [SQRT_W-1:0] res_s [ND];
	logic [SQRT_W-1:0] res_n [ND];
	logic [SIDE_W-1:0] side_s [NS];
	logic [SIDE_W-1:0] side_n [NS];

	assign v_prev = {v_s[NS-2:0], in_valid};
	assign in_stall = !adv[0];
	assign sqy_p = ay * ay;
	assign sqz_p = az * az;

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_adv
			if (k == NS - 1) begin : g_last
				assign adv[k] = !v_s[k] || !out_stall;
			end else begin : g_mid
				assign adv[k] = !v_s[k] || adv[k+1];
			end
			if (k == 0) begin : g_s0
				assign side_n[k] = side_in;
			end else begin : g_sn
				assign side_n[k] = side_s[k-1];
			end
		end
		for (k = 0; k < ND; k++) begin : g_dig
			if (k == 0) begin : g_sum
				assign n_n[k] = SQRT_W'(SQRT_W'(sqy_s0) + SQRT_W'(sqz_s0)) << (2 * PG);
				assign res_n[k] = '0;
			end else begin : g_step
				localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (62 - 2 * (k - 1));
				logic [SQRT_W-1:0] trial;
				logic ge;
				assign trial = res_s[k-1] + BIT;
				assign ge = n_s[k-1] >= trial;
				assign n_n[k] = ge ? n_s[k-1] - trial : n_s[k-1];
				assign res_n[k] = ge ? (res_s[k-1] >> 1) + BIT : res_s[k-1] >> 1;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (adv[i]) begin
					v_s[i] <= v_prev[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sqy_s0 <= sqy_p;
			sqz_s0 <= sqz_p;
		end
		for (int i = 0; i < NS; i++) begin
			if (adv[i]) begin
				side_s[i] <= side_n[i];
			end
		end
		for (int i = 0; i < ND; i++) begin
			if (adv[i+1]) begin
				n_s[i] <= n_n[i];
				res_s[i] <= res_n[i];
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign root = res_s[ND-1][ROOT_W-1:0];
	assign side_out = side_s[NS-1];

endmodule

### sv/thc_vec.sv
module thc_vec #(
	parameter int W = 16,
	parameter int STEPS = 16,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [W-1:0] x,
	input logic signed [W-1:0] y,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	input logic out_stall,
	output logic signed [thc_pkg::ANG_W-1:0] angle,
	output logic [SIDE_W-1:0] side_out
);
	import thc_pkg::*;

	localparam int IW = W + 2;
	localparam int NS = STEPS + 1;

	logic [NS-1:0] v_s, v_prev, adv, zero_s, zero_n;
	logic signed [IW-1:0] x_s [NS];
	logic signed [IW-1:0] y_s [NS];
	logic signed [IW-1:0] x_n [NS];
	logic signed [IW-1:0] y_n [NS];
	logic signed [ANG_W-1:0] z_s [NS];
	logic signed [ANG_W-1:0] z_n [NS];
	logic [SIDE_W-1:0] side_s [NS];
	logic [SIDE_W-1:0] side_n [NS];
	logic signed [IW-1:0] xe, ye;

	assign v_prev = {v_s[NS-2:0], in_valid};
	assign in_stall = !adv[0];
	assign xe = IW'(x);
	assign ye = IW'(y);

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_st
			if (k == NS - 1) begin : g_last
				assign adv[k] = !v_s[k] || !out_stall;
			end else begin : g_mid
				assign adv[k] = !v_s[k] || adv[k+1];
			end
			if (k == 0) begin : g_pre
				// left half-plane: turn by half a turn first
				assign x_n[k] = x[W-1] ? -xe : xe;
				assign y_n[k] = x[W-1] ? -ye : ye;
				assign z_n[k] = x[W-1] ? HALF_TURN : '0;
				assign zero_n[k] = (x == '0) && (y == '0);
				assign side_n[k] = side_in;
			end else begin : g_it
				logic signed [IW-1:0] dx, dy;
				logic neg;
				assign dx = y_s[k-1] >>> (k - 1);
				assign dy = x_s[k-1] >>> (k - 1);
				assign neg = y_s[k-1][IW-1];
				assign x_n[k] = neg ? x_s[k-1] - dx : x_s[k-1] + dx;
				assign y_n[k] = neg ? y_s[k-1] + dy : y_s[k-1] - dy;
				assign z_n[k] = neg ? z_s[k-1] - ATAN_TAB[k-1] : z_s[k-1] + ATAN_TAB[k-1];
				assign zero_n[k] = zero_s[k-1];
				assign side_n[k] = side_s[k-1];
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (adv[i]) begin
					v_s[i] <= v_prev[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NS; i++) begin
			if (adv[i]) begin
				x_s[i] <= x_n[i];
				y_s[i] <= y_n[i];
				z_s[i] <= z_n[i];
				zero_s[i] <= zero_n[i];
				side_s[i] <= side_n[i];
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign angle = zero_s[NS-1] ? '0 : z_s[NS-1];
	assign side_out = side_s[NS-1];

endmodule

### sv/thc_rot.sv
module thc_rot #(
	parameter int W = 44,
	parameter int STEPS = 16,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [W-1:0] x,
	input logic signed [W-1:0] y,
	input logic signed [thc_pkg::ANG_W-1:0] z,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	input logic out_stall,
	output logic signed [W+1:0] rx,
	output logic signed [W+1:0] ry,
	output logic [SIDE_W-1:0] side_out
);
	import thc_pkg::*;

	localparam int OW = W + 2;
	localparam int NS = STEPS + 1;

	logic [NS-1:0] v_s, v_prev, adv;
	logic signed [OW-1:0] x_s [NS];
	logic signed [OW-1:0] y_s [NS];
	logic signed [OW-1:0] x_n [NS];
	logic signed [OW-1:0] y_n [NS];
	logic signed [ANG_W-1:0] z_s [NS];
	logic signed [ANG_W-1:0] z_n [NS];
	logic [SIDE_W-1:0] side_s [NS];
	logic [SIDE_W-1:0] side_n [NS];
	logic signed [OW-1:0] xe, ye;
	logic flip;

	assign v_prev = {v_s[NS-2:0], in_valid};
	assign in_stall = !adv[0];
	assign xe = OW'(x);
	assign ye = OW'(y);
	assign flip = (z > QUARTER_TURN) || (z < NEG_QUARTER_TURN);

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_st
			if (k == NS - 1) begin : g_last
				assign adv[k] = !v_s[k] || !out_stall;
			end else begin : g_mid
				assign adv[k] = !v_s[k] || adv[k+1];
			end
			if (k == 0) begin : g_pre
				// bring the angle into the right half-plane; half a turn wraps either way
				assign x_n[k] = flip ? -xe : xe;
				assign y_n[k] = flip ? -ye : ye;
				assign z_n[k] = flip ? z + HALF_TURN : z;
				assign side_n[k] = side_in;
			end else begin : g_it
				logic signed [OW-1:0] dx, dy;
				logic neg;
				assign dx = y_s[k-1] >>> (k - 1);
				assign dy = x_s[k-1] >>> (k - 1);
				assign neg = z_s[k-1][ANG_W-1];
				assign x_n[k] = neg ? x_s[k-1] + dx : x_s[k-1] - dx;
				assign y_n[k] = neg ? y_s[k-1] - dy : y_s[k-1] + dy;
				assign z_n[k] = neg ? z_s[k-1] + ATAN_TAB[k-1] : z_s[k-1] - ATAN_TAB[k-1];
				assign side_n[k] = side_s[k-1];
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (adv[i]) begin
					v_s[i] <= v_prev[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NS; i++) begin
			if (adv[i]) begin
				x_s[i] <= x_n[i];
				y_s[i] <= y_n[i];
				z_s[i] <= z_n[i];
				side_s[i] <= side_n[i];
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign rx = x_s[NS-1];
	assign ry = y_s[NS-1];
	assign side_out = side_s[NS-1];

endmodule

### sv/thc_scale.sv
module thc_scale #(
	parameter int TW = 46,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [TW-1:0] t,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	input logic out_stall,
	output logic signed [TW-1:0] ts,
	output logic [SIDE_W-1:0] side_out
);
	import thc_pkg::*;

	localparam int LO_W = TW / 2;
	localparam int HW = TW - LO_W;
	localparam int PW = TW + K_W + 1;

	logic v_s1, v_s2, adv1, adv2;
	logic signed [HW+K_W:0] ph_s1;
	logic [LO_W+K_W-1:0] pl_s1;
	logic signed [TW-1:0] t_s2;
	logic [SIDE_W-1:0] side_s1, side_s2;
	logic signed [HW-1:0] hi;
	logic [LO_W-1:0] lo;
	logic signed [PW-1:0] acc;

	assign adv2 = !v_s2 || !out_stall;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;

	// split the gain correction into two narrow partial products
	assign hi = t[TW-1:LO_W];
	assign lo = t[LO_W-1:0];
	assign acc = (PW'(ph_s1) <<< LO_W) + PW'(pl_s1) + PW'(ROUND_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ph_s1 <= hi * $signed({1'b0, INV_GAIN_Q16});
			pl_s1 <= lo * INV_GAIN_Q16;
			side_s1 <= side_in;
		end
		if (adv2) begin
			t_s2 <= acc[TW+15:16];
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign ts = t_s2;
	assign side_out = side_s2;

endmodule

### sv/tilt_compensated_heading.sv
// Throughput: one sample beat per cycle while result_stall is low; every stage has
// its own valid bit, so bubbles close up and a stalled result does not block new
// samples until the line fills.
// Reset: arst_n clears only the stage valid bits; datapath registers are not reset.
module tilt_compensated_heading #(
	parameter int SAMPLE_WIDTH = thc_pkg::DEF_SAMPLE_WIDTH,
	parameter int CORDIC_STEPS = thc_pkg::DEF_CORDIC_STEPS
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input thc_pkg::sample_t sample,
	output logic result_valid,
	input logic result_stall,
	output thc_pkg::result_t result
);
	import thc_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int PG = 32 - SW;          // pitch guard shift
	localparam int MG = MAG_W - SW;       // magnetometer guard shift
	localparam int PV_W = ROOT_W + 2;     // pitch vector width
	localparam int R1_W = MAG_W + 2;      // roll rotation output width
	localparam int R2_W = R1_W + 2;       // pitch rotation output width

	// sideband payloads riding along each section
	typedef struct packed {
		logic signed [SW-1:0] ax;
		logic signed [SW-1:0] ay;
		logic signed [SW-1:0] az;
		logic signed [SW-1:0] mx;
		logic signed [SW-1:0] my;
		logic signed [SW-1:0] mz;
	} sq_side_t;

	typedef struct packed {
		logic [ROOT_W-1:0] r;
		logic signed [SW-1:0] ax;
		logic signed [SW-1:0] mx;
		logic signed [SW-1:0] my;
		logic signed [SW-1:0] mz;
	} roll_side_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] roll;
		logic signed [SW-1:0] mx;
		logic signed [SW-1:0] my;
		logic signed [SW-1:0] mz;
	} pitch_side_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] roll;
		logic signed [ANG_W-1:0] pitch;
		logic signed [SW-1:0] mx;
	} rot1_side_t;

	typedef struct packed {
		logic signed [R1_W-1:0] hy;
		logic signed [ANG_W-1:0] roll;
		logic signed [ANG_W-1:0] pitch;
		logic signed [SW-1:0] mx;
	} scale_side_t;

	typedef struct packed {
		logic signed [R1_W-1:0] hy;
		logic signed [ANG_W-1:0] roll;
		logic signed [ANG_W-1:0] pitch;
	} rot2_side_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] roll;
		logic signed [ANG_W-1:0] pitch;
	} head_side_t;

	sq_side_t sq_in, sq_out;
	roll_side_t roll_in, roll_out;
	pitch_side_t pitch_in, pitch_out;
	rot1_side_t rot1_in, rot1_out;
	scale_side_t scale_in, scale_out;
	rot2_side_t rot2_in, rot2_out;
	head_side_t head_in, head_out;

	logic sq_valid, sq_stall, roll_valid, roll_stall, pitch_valid, pitch_stall;
	logic rot1_valid, rot1_stall, scale_valid, scale_stall, rot2_valid, rot2_stall;
	logic [ROOT_W-1:0] root;
	logic signed [ANG_W-1:0] roll_ang, pitch_ang, head_ang, neg_pitch;
	logic signed [PV_W-1:0] px, py;
	logic signed [MAG_W-1:0] mxs, mys, mzs;
	logic signed [R1_W-1:0] hy, t_raw, t_adj, mx_ext;
	logic signed [R2_W-1:0] hx, t_unused, neg_hy;
	logic [ANG_W-1:0] p_round;
	logic signed [FIELD_W-1:0] p16;

	// Keep only SAMPLE_WIDTH bits of each field, sign-extended.
	assign sq_in.ax = SW'(sample.accel_x);
	assign sq_in.ay = SW'(sample.accel_y);
	assign sq_in.az = SW'(sample.accel_z);
	assign sq_in.mx = SW'(sample.mag_x);
	assign sq_in.my = SW'(sample.mag_y);
	assign sq_in.mz = SW'(sample.mag_z);

	// Section 1: radius sqrt(ay^2 + az^2) with the pitch guard bits.
	thc_sqrt #(.SW(SW), .SIDE_W($bits(sq_side_t))) u_sqrt (
		.clk, .arst_n,
		.in_valid(sample_valid), .in_stall(sample_stall),
		.ay(sq_in.ay), .az(sq_in.az), .side_in(sq_in),
		.out_valid(sq_valid), .out_stall(sq_stall),
		.root(root), .side_out(sq_out)
	);

	// Section 2: roll = atan2(ay, az).
	assign roll_in.r = root;
	assign roll_in.ax = sq_out.ax;
	assign roll_in.mx = sq_out.mx;
	assign roll_in.my = sq_out.my;
	assign roll_in.mz = sq_out.mz;

	thc_vec #(.W(SW), .STEPS(CORDIC_STEPS), .SIDE_W($bits(roll_side_t))) u_roll (
		.clk, .arst_n,
		.in_valid(sq_valid), .in_stall(sq_stall),
		.x(sq_out.az), .y(sq_out.ay), .side_in(roll_in),
		.out_valid(roll_valid), .out_stall(roll_stall),
		.angle(roll_ang), .side_out(roll_out)
	);

	// Section 3: pitch = atan2(-ax, radius), both at the same guard scale.
	assign px = PV_W'(roll_out.r);
	assign py = -(PV_W'(roll_out.ax) <<< PG);
	assign pitch_in.roll = roll_ang;
	assign pitch_in.mx = roll_out.mx;
	assign pitch_in.my = roll_out.my;
	assign pitch_in.mz = roll_out.mz;

	thc_vec #(.W(PV_W), .STEPS(CORDIC_STEPS), .SIDE_W($bits(pitch_side_t))) u_pitch (
		.clk, .arst_n,
		.in_valid(roll_valid), .in_stall(roll_stall),
		.x(px), .y(py), .side_in(pitch_in),
		.out_valid(pitch_valid), .out_stall(pitch_stall),
		.angle(pitch_ang), .side_out(pitch_out)
	);

	// Section 4: rotate (my, mz) by roll; x out is hy, y out is the tilted z term.
	assign mys = MAG_W'(pitch_out.my) <<< MG;
	assign mzs = MAG_W'(pitch_out.mz) <<< MG;
	assign rot1_in.roll = pitch_out.roll;
	assign rot1_in.pitch = pitch_ang;
	assign rot1_in.mx = pitch_out.mx;

	thc_rot #(.W(MAG_W), .STEPS(CORDIC_STEPS), .SIDE_W($bits(rot1_side_t))) u_rot_roll (
		.clk, .arst_n,
		.in_valid(pitch_valid), .in_stall(pitch_stall),
		.x(mys), .y(mzs), .z(pitch_out.roll), .side_in(rot1_in),
		.out_valid(rot1_valid), .out_stall(rot1_stall),
		.rx(hy), .ry(t_raw), .side_out(rot1_out)
	);

	// Section 5: strip the CORDIC gain from the z term so hx ends with the same gain as hy.
	assign scale_in.hy = hy;
	assign scale_in.roll = rot1_out.roll;
	assign scale_in.pitch = rot1_out.pitch;
	assign scale_in.mx = rot1_out.mx;

	thc_scale #(.TW(R1_W), .SIDE_W($bits(scale_side_t))) u_scale (
		.clk, .arst_n,
		.in_valid(rot1_valid), .in_stall(rot1_stall),
		.t(t_raw), .side_in(scale_in),
		.out_valid(scale_valid), .out_stall(scale_stall),
		.ts(t_adj), .side_out(scale_out)
	);

	// Section 6: rotate (mx, t) by -pitch; x out is hx.
	assign mxs = MAG_W'(scale_out.mx) <<< MG;
	assign mx_ext = R1_W'(mxs);
	assign neg_pitch = -scale_out.pitch;
	assign rot2_in.hy = scale_out.hy;
	assign rot2_in.roll = scale_out.roll;
	assign rot2_in.pitch = scale_out.pitch;

	thc_rot #(.W(R1_W), .STEPS(CORDIC_STEPS), .SIDE_W($bits(rot2_side_t))) u_rot_pitch (
		.clk, .arst_n,
		.in_valid(scale_valid), .in_stall(scale_stall),
		.x(mx_ext), .y(t_adj), .z(neg_pitch), .side_in(rot2_in),
		.out_valid(rot2_valid), .out_stall(rot2_stall),
		.rx(hx), .ry(t_unused), .side_out(rot2_out)
	);

	// Section 7: heading = atan2(-hy, hx). The last stage register is the result register.
	assign neg_hy = -R2_W'(rot2_out.hy);
	assign head_in.roll = rot2_out.roll;
	assign head_in.pitch = rot2_out.pitch;

	thc_vec #(.W(R2_W), .STEPS(CORDIC_STEPS), .SIDE_W($bits(head_side_t))) u_heading (
		.clk, .arst_n,
		.in_valid(rot2_valid), .in_stall(rot2_stall),
		.x(hx), .y(neg_hy), .side_in(head_in),
		.out_valid(result_valid), .out_stall(result_stall),
		.angle(head_ang), .side_out(head_out)
	);

	// Round angles to 16 bits; the heading wraps by truncation, pitch clamps to +/- a quarter turn.
	assign p_round = head_out.pitch + ROUND_HALF;
	assign p16 = p_round[ANG_W-1:ANG_W-FIELD_W];

	always_comb begin
		result.heading_angle = ang16(head_ang);
		result.roll_angle = ang16(head_out.roll);
		if (p16 > 16'sd16384) begin
			result.pitch_angle = 16'sd16384;
		end else if (p16 < -16'sd16384) begin
			result.pitch_angle = -16'sd16384;
		end else begin
			result.pitch_angle = p16;
		end
	end

	// the y output of the pitch rotation is not needed
	logic unused_t;
	assign unused_t = ^t_unused;

endmodule

### test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import thc_pkg::*;

	// Pipeline depth at the default step count; the drain wait and the
	// long receiver hold-off are sized from it.
	localparam int LATENCY = 41 + 5 * DEF_CORDIC_STEPS;
	localparam int STEPS = DEF_CORDIC_STEPS;
	localparam logic signed [63:0] HALF64 = 64'sd2147483648;
	localparam logic signed [63:0] QUARTER64 = 64'sd1073741824;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	sample_t sample;
	logic result_valid;
	logic result_stall;
	result_t result;

	tilt_compensated_heading dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// Expected result beats, oldest first.
	result_t heading_q[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// A long hold is requested by bumping hold_reqs; the receiver counts it down.
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop; generous against about 420 beats at heavy idling.
	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

	// Floor shift on a signed 64-bit value.
	function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v, input int s);
		return v >>> s;
	endfunction

	// Binary-angle atan2 by vectoring, 2^32 units per turn.
	function automatic logic signed [63:0] cordic_atan2(input logic signed [63:0] x_in,
			input logic signed [63:0] y_in);
		logic signed [63:0] x, y, z, dx, dy;
		x = x_in;
		y = y_in;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? HALF64 : -HALF64;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (y >= 0) begin
				x = x + dx; y = y - dy; z = z + 64'(ATAN_TAB[i]);
			end else begin
				x = x - dx; y = y + dy; z = z - 64'(ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	// Rotate (x, y) by angle z; the output carries the CORDIC gain.
	function automatic void cordic_turn(inout logic signed [63:0] x,
			inout logic signed [63:0] y, input logic signed [63:0] z_in);
		logic signed [63:0] z, dx, dy;
		z = z_in;
		if (z > QUARTER64) begin
			x = -x; y = -y; z = z - HALF64;
		end else if (z < -QUARTER64) begin
			x = -x; y = -y; z = z + HALF64;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - 64'(ATAN_TAB[i]);
			end else begin
				x = x + dx; y = y - dy; z = z + 64'(ATAN_TAB[i]);
			end
		end
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n_in);
		logic [63:0] n, res, b;
		n = n_in;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [63:0] round_to16(input logic signed [63:0] z);
		return floor_shr(z + 64'sd32768, 16);
	endfunction

	function automatic result_t predict_heading(input sample_t s);
		logic signed [63:0] ax, ay, az, mx, my, mz, roll, pitch, r, hy, t, hx, p16;
		logic signed [63:0] h16, r16;
		logic [63:0] sum;
		result_t res;
		ax = 64'(s.accel_x);
		ay = 64'(s.accel_y);
		az = 64'(s.accel_z);
		mx = 64'(s.mag_x) <<< (MAG_W - FIELD_W);
		my = 64'(s.mag_y) <<< (MAG_W - FIELD_W);
		mz = 64'(s.mag_z) <<< (MAG_W - FIELD_W);
		roll = cordic_atan2(az, ay);
		sum = ay * ay + az * az;
		r = int_sqrt(sum << (2 * (ANG_W - FIELD_W)));
		pitch = cordic_atan2(r, -ax <<< (ANG_W - FIELD_W));
		hy = my;
		t = mz;
		cordic_turn(hy, t, roll);
		t = floor_shr(t * 64'sd39797 + 64'sd32768, 16);
		hx = mx;
		cordic_turn(hx, t, -pitch);
		p16 = round_to16(pitch);
		if (p16 > 16384)
			p16 = 16384;
		if (p16 < -16384)
			p16 = -16384;
		h16 = round_to16(cordic_atan2(hx, -hy));
		r16 = round_to16(roll);
		res.heading_angle = h16[15:0];
		res.roll_angle = r16[15:0];
		res.pitch_angle = p16[15:0];
		return res;
	endfunction

	// Offer one sample beat, holding it until accepted. Valid stays high
	// straight into the next beat when the caller sends back to back.
	task automatic send_sample(input sample_t s);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		heading_q.push_back(predict_heading(s));
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	function automatic logic [15:0] rand_field();
		case ($urandom_range(5, 0))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(64, 0)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		s.accel_x = rand_field();
		s.accel_y = rand_field();
		s.accel_z = rand_field();
		s.mag_x = rand_field();
		s.mag_y = rand_field();
		s.mag_z = rand_field();
		return s;
	endfunction

	// Receiver: drive stall, check each accepted result beat.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (heading_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat %h", result);
			end else begin
				want = heading_q.pop_front();
				if (result.heading_angle !== want.heading_angle
						|| result.roll_angle !== want.roll_angle
						|| result.pitch_angle !== want.pitch_angle) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("exp/got heading %0d/%0d roll %0d/%0d pitch %0d/%0d",
							want.heading_angle, result.heading_angle,
							want.roll_angle, result.roll_angle,
							want.pitch_angle, result.pitch_angle);
				end
			end
		end
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_reqs != hold_done) begin
			hold_done <= hold_reqs;
			hold_left <= 3 * LATENCY;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= (recv_idle_pct > 0) && ($urandom_range(99, 0) < recv_idle_pct);
		end
	end

	task automatic test_directed();
		sample_t s;
		logic [15:0] ext [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		// Zero vectors everywhere.
		send_sample('0);
		// Negative x axis for roll: accel_z negative, accel_y zero.
		s = '0; s.accel_z = 16'h8000; s.mag_x = 16'h4000;
		send_sample(s);
		s.accel_y = 16'hFFFF; send_sample(s);
		s.accel_y = 16'h0001; send_sample(s);
		// Pitch at the poles, where rounding may pass a quarter turn.
		s = '0; s.accel_x = 16'h8000; s.mag_y = 16'h1234; send_sample(s);
		s.accel_x = 16'h7FFF; send_sample(s);
		// Heading around the wrap: magnetic vector near +x with small y.
		s = '0; s.accel_z = 16'h4000; s.mag_x = 16'h7FFF; s.mag_y = 16'h0001; send_sample(s);
		s.mag_y = 16'hFFFF; send_sample(s);
		s.mag_y = 16'h0000; send_sample(s);
		// Field extremes, each axis in turn.
		for (int k = 0; k < 4; k++) begin
			s.accel_x = ext[k]; s.accel_y = ext[(k+1)%4]; s.accel_z = ext[(k+2)%4];
			s.mag_x = ext[(k+3)%4]; s.mag_y = ext[k]; s.mag_z = ext[(k+2)%4];
			send_sample(s);
		end
		s = '1; send_sample(s);
		s = {6{16'h8000}}; send_sample(s);
		s = {6{16'h7FFF}}; send_sample(s);
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++)
			send_sample(rand_sample());
	endtask

	// Hold the receiver off long enough that the line fills and the
	// block stalls its input while beats keep coming.
	task automatic test_backpressure();
		hold_reqs++;
		test_random(LATENCY + 40);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (heading_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 33; recv_idle_pct = 51;
		test_random(90);
		send_idle_pct = 51; recv_idle_pct = 33;
		test_random(90);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(60);
		test_backpressure();
		drain();
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

### tilt_compensated_heading.f
sv/thc_pkg.sv
sv/thc_sqrt.sv
sv/thc_vec.sv
sv/thc_rot.sv
sv/thc_scale.sv
sv/tilt_compensated_heading.sv
test/tb.sv
